### hw/rtl/mtm_pkg.sv
package mtm_pkg;

   localparam int ENTRIES     = 64;
   localparam int SLOT_W      = 6;
   localparam int CNT_W       = 7;
   localparam int STAGE_CELLS = 4;
   localparam int STAGES      = ENTRIES / STAGE_CELLS;
   localparam int PASS_W      = $clog2(STAGES + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_NOTFND = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   localparam logic CSR_WILDCARD = 1'b0;
   localparam logic CSR_SEQCHECK = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK
   } state_type;

   // query broadcast to every cell
   typedef struct packed {
      cmd_type            cmd;
      logic [15:0]        ctx;
      logic signed [15:0] src;
      logic signed [31:0] tag;
      logic signed [16:0] seq;
      logic [31:0]        handle;
      logic [SLOT_W-1:0]  slot;
      logic               wild;
      logic               seq_en;
      logic [CNT_W-1:0]   count;
   } query_type;

   // candidate carried down the chain
   typedef struct packed {
      logic               hit;
      logic               exact;
      logic signed [15:0] src;
      logic signed [31:0] tag;
      logic [SLOT_W-1:0]  age;
      logic [SLOT_W-1:0]  slot;
      logic [31:0]        handle;
      logic               free_seen;
      logic [SLOT_W-1:0]  free_slot;
      logic               rm_hit;
      logic [SLOT_W-1:0]  rm_age;
   } cand_type;

endpackage

### hw/rtl/mtm_cell.sv
module mtm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [mtm_pkg::SLOT_W-1:0] index,
   input  mtm_pkg::query_type       query,
   input  logic                     commit,
   input  logic                     ins_sel,
   input  logic                     rm_commit,
   input  logic [mtm_pkg::SLOT_W-1:0] rm_age,
   input  mtm_pkg::cand_type        cand_i,
   output mtm_pkg::cand_type        cand_o
);
   import mtm_pkg::*;

   logic               valid_ff;
   logic [15:0]        ctx_ff;
   logic signed [15:0] src_ff;
   logic signed [31:0] tag_ff;
   logic signed [16:0] seq_ff;
   logic [31:0]        req_ff;
   logic [SLOT_W-1:0]  age_ff;
   logic               seq_ok, exact, wmatch, better;
   logic               me_rm;

   always_comb begin
      seq_ok = !query.seq_en || (query.seq == -17'sd1) || (seq_ff <= query.seq);
      exact  = valid_ff && ctx_ff == query.ctx && src_ff == query.src &&
               tag_ff == query.tag && seq_ok;
      wmatch = valid_ff && ctx_ff == query.ctx && seq_ok && query.wild &&
               (query.src < 0 || query.tag < 0) &&
               (query.src < 0 || src_ff == query.src) &&
               (query.tag < 0 || tag_ff == query.tag);
      me_rm  = valid_ff && query.slot == index;
      // pick the better of the incoming candidate and this entry
      better = 1'b0;
      if (exact) begin
         better = !cand_i.exact || age_ff < cand_i.age;
      end else if (wmatch && !cand_i.exact) begin
         better = !cand_i.hit || src_ff < cand_i.src ||
                  (src_ff == cand_i.src && (tag_ff < cand_i.tag ||
                  (tag_ff == cand_i.tag && age_ff < cand_i.age)));
      end
      cand_o = cand_i;
      if (better) begin
         cand_o.hit    = 1'b1;
         cand_o.exact  = exact;
         cand_o.src    = src_ff;
         cand_o.tag    = tag_ff;
         cand_o.age    = age_ff;
         cand_o.slot   = index;
         cand_o.handle = req_ff;
      end
      if (!valid_ff && !cand_i.free_seen) begin
         cand_o.free_seen = 1'b1;
         cand_o.free_slot = index;
      end
      if (me_rm) begin
         cand_o.rm_hit = 1'b1;
         cand_o.rm_age = age_ff;
      end
   end

   // update entry on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (commit) begin
         if (query.cmd == CMD_CLEAR) begin
            valid_ff <= 1'b0;
         end else if (query.cmd == CMD_INSERT && ins_sel) begin
            valid_ff <= 1'b1;
         end else if (rm_commit && query.slot == index) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit && query.cmd == CMD_INSERT && ins_sel) begin
         ctx_ff <= query.ctx;
         src_ff <= query.src;
         tag_ff <= query.tag;
         seq_ff <= query.seq;
         req_ff <= query.handle;
         age_ff <= query.count[SLOT_W-1:0];
      end else if (rm_commit && valid_ff && age_ff > rm_age) begin
         age_ff <= age_ff - 1'b1;
      end
   end
endmodule

### hw/rtl/mtm_chain.sv
module mtm_chain (
   input  logic                clock,
   input  logic                reset,
   input  mtm_pkg::query_type  query,
   input  logic                commit,
   output mtm_pkg::cand_type   result
);
   import mtm_pkg::*;

   cand_type chain [ENTRIES+1];
   cand_type link [ENTRIES];
   logic     rm_commit;

   assign chain[0]  = '0;
   assign result    = chain[ENTRIES];
   assign rm_commit = commit && query.cmd == CMD_REMOVE && chain[ENTRIES].rm_hit;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mtm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .index     (SLOT_W'(i)),
         .query     (query),
         .commit    (commit),
         .ins_sel   (chain[ENTRIES].free_seen && chain[ENTRIES].free_slot == SLOT_W'(i)),
         .rm_commit (rm_commit),
         .rm_age    (chain[ENTRIES].rm_age),
         .cand_i    (chain[i]),
         .cand_o    (link[i])
      );

      // register the candidate at the end of each stage
      if ((i + 1) % STAGE_CELLS == 0) begin : g_stage
         cand_type cand_ff;
         always_ff @(posedge clock) begin
            cand_ff <= link[i];
         end
         assign chain[i+1] = cand_ff;
      end else begin : g_pass
         assign chain[i+1] = link[i];
      end
   end
endmodule

### hw/rtl/message_tag_match_table.sv
// Receive-matching table of 64 entries built as a chain of cells, one per entry,
// with a register after every four cells (16 stages). A request is taken only
// when no command is in flight. The candidate then moves one stage per cycle
// (compare of every entry against the query, best match, first free slot and
// remove lookup resolved along the chain); once the pass counter has run through
// all stages and the result register is free, the table update commits and the
// result register loads, and the next request is taken in the cycle after the
// commit. The result register parts the two sides: a waiting result does not
// block the next request, only the commit of the one after it.
module message_tag_match_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [15:0]          req_context_id,
   input  logic signed [15:0]   req_source,
   input  logic signed [31:0]   req_tag,
   input  logic signed [16:0]   req_seqno,
   input  logic [31:0]          req_handle,
   input  logic [5:0]           req_slot,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic                 rsp_found,
   output logic [31:0]          rsp_match_handle,
   output logic [5:0]           rsp_match_slot,
   output logic                 rsp_table_empty,
   output logic [6:0]           rsp_live_entries,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic                 csr_data
);
   import mtm_pkg::*;

   state_type         state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   query_type         query_ff;
   cand_type          result;
   logic              wild_ff, seqen_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              commit;
   status_type        status_in;

   assign csr_ready = 1'b1;

   mtm_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .query  (query_ff),
      .commit (commit),
      .result (result)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wild_ff  <= 1'b1;
         seqen_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_WILDCARD) wild_ff <= csr_data;
         else seqen_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   // count stages of the pass, then commit once the result register is free
   always_comb begin
      state_in  = state_ff;
      pass_in   = '0;
      req_stall = 1'b1;
      commit    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) state_in = S_WORK;
         end
         S_WORK: begin
            pass_in = pass_ff;
            if (pass_ff != PASS_W'(STAGES)) begin
               pass_in = pass_ff + 1'b1;
            end else if (!rsp_valid || !rsp_stall) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // capture transfer
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         query_ff.cmd    <= cmd_type'(req_cmd);
         query_ff.ctx    <= req_context_id;
         query_ff.src    <= req_source;
         query_ff.tag    <= req_tag;
         query_ff.seq    <= req_seqno;
         query_ff.handle <= req_handle;
         query_ff.slot   <= req_slot;
         query_ff.wild   <= wild_ff;
         query_ff.seq_en <= seqen_ff;
         query_ff.count  <= count_ff;
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      case (query_ff.cmd)
         CMD_INSERT: begin
            if (result.free_seen) count_in = count_ff + 1'b1;
            else status_in = ST_FULL;
         end
         CMD_FIND:   if (!result.hit) status_in = ST_NOTFND;
         CMD_REMOVE: begin
            if (result.rm_hit) count_in = count_ff - 1'b1;
            else status_in = ST_EMPTY;
         end
         default:    count_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (commit) count_ff <= count_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (commit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status       <= status_in;
         rsp_found        <= query_ff.cmd == CMD_FIND && result.hit;
         rsp_match_handle <= (query_ff.cmd == CMD_FIND && result.hit) ? result.handle : '0;
         case (query_ff.cmd)
            CMD_INSERT: rsp_match_slot <= result.free_seen ? result.free_slot : '0;
            CMD_FIND:   rsp_match_slot <= result.hit ? result.slot : '0;
            CMD_REMOVE: rsp_match_slot <= query_ff.slot;
            default:    rsp_match_slot <= '0;
         endcase
         rsp_table_empty  <= count_in == '0;
         rsp_live_entries <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES)) else $error("live count over capacity");
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid) else $error("result missing after commit");
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_table_empty == (rsp_live_entries == '0)))
      else $error("empty flag mismatch");
`endif
endmodule
